// ===== design/mma_pkg.sv =====
package mma_pkg;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned TIME_W = 32;
    localparam int unsigned LEN_W  = 2;

    localparam logic [BYTE_W-1:0] BYTE_FF      = 8'hFF;
    localparam logic [BYTE_W-1:0] NOTE_OFF_MSK = 8'h8F;
    localparam logic [3:0]        NOTE_ON_HI   = 4'h9;

    localparam logic [LEN_W-1:0] LEN_NONE = 2'd0;
    localparam logic [LEN_W-1:0] LEN_ONE  = 2'd1;
    localparam logic [LEN_W-1:0] LEN_TWO  = 2'd2;
    localparam logic [LEN_W-1:0] LEN_THREE = 2'd3;

    // configuration register indexes
    localparam logic CFG_DROP_FF     = 1'b0;
    localparam logic CFG_TIME_ORIGIN = 1'b1;

    typedef struct packed {
        logic [TIME_W-1:0] event_ms;
        logic [LEN_W-1:0]  msg_length;
        logic [BYTE_W-1:0] msg_data2;
        logic [BYTE_W-1:0] msg_data1;
        logic [BYTE_W-1:0] msg_status;
    } t_msg;

    // message length for a status byte (bit 7 assumed set)
    function automatic logic [LEN_W-1:0] f_msg_len(input logic [BYTE_W-1:0] s);
        logic [LEN_W-1:0] len;
        case (s[6:4])
            3'd4, 3'd5: len = LEN_TWO;
            3'd7: begin
                case (s[3:0])
                    4'h0:       len = LEN_NONE;
                    4'h1, 4'h3: len = LEN_TWO;
                    4'h2:       len = LEN_THREE;
                    default:    len = LEN_ONE;
                endcase
            end
            default: len = LEN_THREE;
        endcase
        return len;
    endfunction

endpackage

// ===== design/midi_message_assembler.sv =====
// MIDI message assembler: takes one raw MIDI byte per transfer with its arrival time
// and emits complete messages (status, up to two data bytes, length, time since the
// configured origin), following running status. A byte is taken every clock cycle
// when the output is not stalled; each byte passes an input register, combinational
// parsing logic and an output register, and a message is offered on the output from
// the output register. Config writes (drop of 0xFF bytes, time
// origin) take effect at once and are meant to happen while no bytes are in flight.
module midi_message_assembler
    import mma_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [31:0] i_cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,  // data_byte[7:0], arrival_ms[39:8]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata   // msg_status[7:0], msg_data1[15:8],
                                       // msg_data2[23:16], msg_length[25:24],
                                       // event_ms[57:26], zeros above
);

    logic              r_drop_ff;
    logic [TIME_W-1:0] r_origin;
    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_byte;
    logic [TIME_W-1:0] r_in_time;

    logic out_free;
    logic step;
    logic res_valid;
    t_msg res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_drop_ff <= 1'b1;
            r_origin  <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_DROP_FF:     r_drop_ff <= i_cfg_wdata[0];
                CFG_TIME_ORIGIN: r_origin  <= i_cfg_wdata[TIME_W-1:0];
                default: ;
            endcase
        end
    end

    assign step          = r_in_valid && out_free;
    assign s_axis_tready = !r_in_valid || out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_byte <= s_axis_tdata[BYTE_W-1:0];
            r_in_time <= s_axis_tdata[BYTE_W +: TIME_W];
        end
    end

    mma_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (step),
        .i_byte      (r_in_byte),
        .i_time      (r_in_time),
        .i_drop_ff   (r_drop_ff),
        .i_origin    (r_origin),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    mma_out_stage u_out (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_res_valid   (res_valid),
        .i_res         (res),
        .o_free        (out_free),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule

// ===== design/mma_parser.sv =====
module mma_parser
    import mma_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  logic [BYTE_W-1:0] i_byte,
    input  logic [TIME_W-1:0] i_time,
    input  logic              i_drop_ff,
    input  logic [TIME_W-1:0] i_origin,
    output logic              o_res_valid,
    output t_msg              o_res
);

    logic [BYTE_W-1:0] r_running, n_running;
    logic              r_status_vld, n_status_vld;
    logic [LEN_W-1:0]  r_collected, n_collected;
    logic [LEN_W-1:0]  r_needed, n_needed;
    logic [BYTE_W-1:0] r_first, n_first;
    logic [TIME_W-1:0] r_msg_time, n_msg_time;

    logic              emit;
    logic [BYTE_W-1:0] emit_d1;
    logic [BYTE_W-1:0] emit_d2;
    logic [LEN_W-1:0]  emit_len;
    logic [LEN_W-1:0]  len_new;
    logic [LEN_W-1:0]  len_run;

    assign len_new = f_msg_len(i_byte);
    assign len_run = f_msg_len(r_running);

    always_comb begin
        n_running    = r_running;
        n_status_vld = r_status_vld;
        n_collected  = r_collected;
        n_needed     = r_needed;
        n_first      = r_first;
        n_msg_time   = r_msg_time;
        emit         = 1'b0;
        emit_d1      = '0;
        emit_d2      = '0;
        emit_len     = LEN_ONE;
        if (!(i_drop_ff && i_byte == BYTE_FF)) begin
            if (r_collected != LEN_NONE) begin
                // open message: any byte fills the next slot
                if (r_collected == LEN_ONE) begin
                    n_first = i_byte;
                    if (r_needed <= LEN_TWO) begin
                        emit        = 1'b1;
                        emit_d1     = i_byte;
                        emit_len    = LEN_TWO;
                        n_collected = LEN_NONE;
                    end else begin
                        n_collected = LEN_TWO;
                    end
                end else begin
                    emit        = 1'b1;
                    emit_d1     = r_first;
                    emit_d2     = i_byte;
                    emit_len    = LEN_THREE;
                    n_collected = LEN_NONE;
                end
            end else if (i_byte[BYTE_W-1]) begin
                n_running    = i_byte;
                n_status_vld = 1'b1;
                n_msg_time   = i_time;
                if (len_new == LEN_ONE) begin
                    emit = 1'b1;
                end else if (len_new != LEN_NONE) begin
                    n_needed    = len_new;
                    n_collected = LEN_ONE;
                end
            end else if (r_status_vld) begin
                // running status reuse
                n_msg_time = i_time;
                case (len_run)
                    LEN_ONE: emit = 1'b1;
                    LEN_TWO: begin
                        emit     = 1'b1;
                        emit_d1  = i_byte;
                        emit_len = LEN_TWO;
                    end
                    LEN_THREE: begin
                        n_first     = i_byte;
                        n_needed    = LEN_THREE;
                        n_collected = LEN_TWO;
                    end
                    default: ;
                endcase
            end
        end
    end

    always_comb begin
        o_res_valid = i_step && emit;
        o_res.msg_status = n_running;
        if (emit_len == LEN_THREE && n_running[7:4] == NOTE_ON_HI && emit_d2 == '0) begin
            o_res.msg_status = n_running & NOTE_OFF_MSK;
        end
        o_res.msg_data1  = emit_d1;
        o_res.msg_data2  = emit_d2;
        o_res.msg_length = emit_len;
        o_res.event_ms   = n_msg_time - i_origin;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_running    <= '0;
            r_status_vld <= 1'b0;
            r_collected  <= LEN_NONE;
            r_needed     <= LEN_NONE;
            r_first      <= '0;
            r_msg_time   <= '0;
        end else if (i_step) begin
            r_running    <= n_running;
            r_status_vld <= n_status_vld;
            r_collected  <= n_collected;
            r_needed     <= n_needed;
            r_first      <= n_first;
            r_msg_time   <= n_msg_time;
        end
    end

endmodule

// ===== design/mma_out_stage.sv =====
module mma_out_stage
    import mma_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_res_valid,
    input  t_msg        i_res,
    output logic        o_free,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata
);

    logic r_valid;
    t_msg r_msg;

    // slot can take a new result this cycle
    assign o_free = !r_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_free && i_res_valid) begin
            r_msg <= i_res;
        end
    end

    assign m_axis_tvalid = r_valid;
    assign m_axis_tdata  = {{(64 - $bits(t_msg)){1'b0}}, r_msg};

endmodule
